### src/lxc_pkg.sv
// Package for the line XOR checksum checker.
// Holds character codes, the verdict type, the result struct and the hex decoder.
// No dependencies.
package lxc_pkg;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] CHAR_NUL  = 8'h00;

    localparam int PLEN_W = 6;

    typedef enum logic [1:0] {
        VERDICT_PLAIN = 2'd0,
        VERDICT_MATCH = 2'd1,
        VERDICT_BAD   = 2'd2
    } verdict_t;

    typedef struct packed {
        logic                valid;
        verdict_t            verdict;
        logic [PLEN_W-1:0]   plen;
    } result_t;

    typedef struct packed {
        logic       bad;
        logic [3:0] nibble;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] b);
        hex_t h;
        h.bad    = 1'b0;
        h.nibble = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            h.nibble = b[3:0];
        end
        else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
        begin
            // 'A'..'F' and 'a'..'f' share the low three bits: value is 9 + low bits
            h.nibble = 4'd9 + {1'b0, b[2:0]};
        end
        else
        begin
            h.bad = 1'b1;
        end
        return h;
    endfunction

endpackage

### src/lxc_line_tracker.sv
// Per-line state for the line XOR checksum checker: running XOR, counters,
// hex digit capture, and the end-of-line verdict. Depends on lxc_pkg.
module lxc_line_tracker #(
    parameter int LINE_BUFFER_SIZE = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    output lxc_pkg::result_t result
);

    localparam int LEN_W = $clog2(LINE_BUFFER_SIZE);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_BUFFER_SIZE - 1);

    logic [LEN_W-1:0] line_length_reg, line_length_next;
    logic [7:0]       running_xor_reg, running_xor_next;
    logic             star_seen_reg, star_seen_next;
    logic             nul_before_star_reg, nul_before_star_next;
    logic [LEN_W-1:0] payload_count_reg, payload_count_next;
    logic [1:0]       digits_reg, digits_next;
    logic [7:0]       check_value_reg, check_value_next;
    logic             digit_invalid_reg, digit_invalid_next;

    logic                  is_eol;
    logic                  clear;
    lxc_pkg::hex_t         hex;
    logic [LEN_W+5:0]      len_ext;
    logic [LEN_W+5:0]      pay_ext;

    assign is_eol  = (rx_byte == lxc_pkg::CHAR_CR) || (rx_byte == lxc_pkg::CHAR_LF);
    assign hex     = lxc_pkg::hex_decode(rx_byte);
    assign len_ext = {6'd0, line_length_reg};
    assign pay_ext = {6'd0, payload_count_reg};

    // line end and overflow both restart the line
    assign clear = is_eol || (line_length_reg >= LEN_LIMIT);

    always_comb
    begin
        result.valid   = step && is_eol && (line_length_reg != '0);
        result.verdict = lxc_pkg::VERDICT_PLAIN;
        result.plen    = len_ext[lxc_pkg::PLEN_W-1:0];
        if (star_seen_reg)
        begin
            result.plen = pay_ext[lxc_pkg::PLEN_W-1:0];
            if (digits_reg == 2'd2 && !digit_invalid_reg && check_value_reg == running_xor_reg)
            begin
                result.verdict = lxc_pkg::VERDICT_MATCH;
            end
            else
            begin
                result.verdict = lxc_pkg::VERDICT_BAD;
            end
        end
    end

    always_comb
    begin
        line_length_next     = line_length_reg;
        running_xor_next     = running_xor_reg;
        star_seen_next       = star_seen_reg;
        nul_before_star_next = nul_before_star_reg;
        payload_count_next   = payload_count_reg;
        digits_next          = digits_reg;
        check_value_next     = check_value_reg;
        digit_invalid_next   = digit_invalid_reg;
        if (step)
        begin
            if (clear)
            begin
                line_length_next     = '0;
                running_xor_next     = '0;
                star_seen_next       = 1'b0;
                nul_before_star_next = 1'b0;
                payload_count_next   = '0;
                digits_next          = '0;
                check_value_next     = '0;
                digit_invalid_next   = 1'b0;
            end
            else
            begin
                line_length_next = line_length_reg + 1'b1;
                if (!star_seen_reg && !nul_before_star_reg)
                begin
                    if (rx_byte == lxc_pkg::CHAR_STAR)
                    begin
                        star_seen_next     = 1'b1;
                        payload_count_next = line_length_reg;
                    end
                    else if (rx_byte == lxc_pkg::CHAR_NUL)
                    begin
                        nul_before_star_next = 1'b1;
                    end
                    else
                    begin
                        running_xor_next = running_xor_reg ^ rx_byte;
                    end
                end
                else if (star_seen_reg && digits_reg != 2'd2)
                begin
                    if (hex.bad)
                    begin
                        digit_invalid_next = 1'b1;
                    end
                    else
                    begin
                        check_value_next = {check_value_reg[3:0], hex.nibble};
                    end
                    digits_next = digits_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg     <= '0;
            running_xor_reg     <= '0;
            star_seen_reg       <= 1'b0;
            nul_before_star_reg <= 1'b0;
            payload_count_reg   <= '0;
            digits_reg          <= '0;
            check_value_reg     <= '0;
            digit_invalid_reg   <= 1'b0;
        end
        else
        begin
            line_length_reg     <= line_length_next;
            running_xor_reg     <= running_xor_next;
            star_seen_reg       <= star_seen_next;
            nul_before_star_reg <= nul_before_star_next;
            payload_count_reg   <= payload_count_next;
            digits_reg          <= digits_next;
            check_value_reg     <= check_value_next;
            digit_invalid_reg   <= digit_invalid_next;
        end
    end

endmodule

### src/line_xor_checksum_checker_core.sv
// Top level of the line XOR checksum checker: input register, line tracker,
// result register. Depends on lxc_pkg and lxc_line_tracker.

// Frames received bytes into CR/LF-terminated lines and reports one verdict per
// non-empty line (plain, checksum match, or bad) with the payload length. One
// byte is taken per cycle while in_ready is high: the byte lands in an input
// register, the line tracker updates its running XOR and counters from it when
// the core advances, and a verdict goes to the result register at the same time,
// so out_valid rises once its CR/LF byte has passed the input register and the
// result register has been loaded. in_ready drops only while a result waits
// in the result register with out_ready low and a byte is already held.
module line_xor_checksum_checker_core #(
    parameter int LINE_BUFFER_SIZE = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] verdict,
    output logic [5:0] payload_length
);

    logic             in_valid_reg;
    logic [7:0]       byte_reg;
    logic             out_valid_reg;
    logic [1:0]       verdict_reg;
    logic [5:0]       plen_reg;
    logic             advance;
    lxc_pkg::result_t result;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    lxc_line_tracker #(
        .LINE_BUFFER_SIZE(LINE_BUFFER_SIZE)
    ) u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .rx_byte(byte_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= result.valid;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
        if (advance && result.valid)
        begin
            verdict_reg <= result.verdict;
            plen_reg    <= result.plen;
        end
    end

    assign out_valid      = out_valid_reg;
    assign verdict        = verdict_reg;
    assign payload_length = plen_reg;

endmodule

### src/lxc_checker.sv
// Port-level checks for line_xor_checksum_checker_core, attached by bind.
// Depends on lxc_pkg and the top level's port list.
module lxc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] rx_byte,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] verdict,
    input logic [5:0] payload_length
);

    // a held result keeps its transaction intact
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(payload_length))
        else $error("result changed while stalled");

    // a new result comes only from a CR/LF byte accepted at the input
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready &&
            (rx_byte == lxc_pkg::CHAR_CR || rx_byte == lxc_pkg::CHAR_LF), 2))
        else $error("result without a line end");

    // with the result side empty, input is never blocked
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict == lxc_pkg::VERDICT_PLAIN || verdict == lxc_pkg::VERDICT_MATCH
            || verdict == lxc_pkg::VERDICT_BAD))
        else $error("unused verdict code");

endmodule

bind line_xor_checksum_checker_core lxc_checker u_lxc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .verdict       (verdict),
    .payload_length(payload_length)
);

### bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for line_xor_checksum_checker_core: random and directed serial lines,
// an in-bench line tracker predicting each verdict, scoreboard on the result channel.
// Depends on lxc_pkg and the RTL under src.
module testbench;

    localparam int LINE_MAX = 64;

    typedef struct {
        lxc_pkg::verdict_t v;
        logic [5:0]        plen;
    } verdict_rec_t;

    typedef enum int {
        LN_GOOD,
        LN_BADSUM,
        LN_SHORT,
        LN_BADHEX,
        LN_PLAIN,
        LN_NULSTAR,
        LN_OVERFLOW,
        LN_NOISE
    } line_kind_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [1:0] verdict;
    logic [5:0] payload_length;

    logic       in_fired = 1'b0;
    logic [7:0] tx_bytes[$];
    verdict_rec_t verdict_q[$];
    int         n_sent  = 0;
    int         n_taken = 0;
    int         n_err   = 0;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         hold_token  = 0;
    int         hold_seen   = 0;
    int         hold_left   = 0;

    // line tracker state
    int         ln_len;
    logic [7:0] ln_xor;
    logic       ln_star;
    logic       ln_nul;
    int         ln_pay;
    int         ln_digits;
    logic [7:0] ln_chk;
    logic       ln_badhex;

    line_xor_checksum_checker_core #(
        .LINE_BUFFER_SIZE(LINE_MAX)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .verdict       (verdict),
        .payload_length(payload_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4ms;
        $display("line_xor_checksum_checker_core regression: fail");
        $finish;
    end

    // -1 for anything that is not a hex digit
    function automatic int nib_of(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39)
            return int'(b) - 'h30;
        if (b >= 8'h41 && b <= 8'h46)
            return int'(b) - 'h41 + 10;
        if (b >= 8'h61 && b <= 8'h66)
            return int'(b) - 'h61 + 10;
        return -1;
    endfunction

    function automatic void clear_line();
        ln_len    = 0;
        ln_xor    = 8'h00;
        ln_star   = 1'b0;
        ln_nul    = 1'b0;
        ln_pay    = 0;
        ln_digits = 0;
        ln_chk    = 8'h00;
        ln_badhex = 1'b0;
    endfunction

    function automatic void track_byte(input logic [7:0] b);
        verdict_rec_t r;
        int           nib;
        if (b == lxc_pkg::CHAR_CR || b == lxc_pkg::CHAR_LF)
        begin
            if (ln_len != 0)
            begin
                if (!ln_star)
                begin
                    r.v    = lxc_pkg::VERDICT_PLAIN;
                    r.plen = ln_len[5:0];
                end
                else
                begin
                    r.plen = ln_pay[5:0];
                    if (ln_digits < 2 || ln_badhex)
                        r.v = lxc_pkg::VERDICT_BAD;
                    else if (ln_chk == ln_xor)
                        r.v = lxc_pkg::VERDICT_MATCH;
                    else
                        r.v = lxc_pkg::VERDICT_BAD;
                end
                verdict_q.push_back(r);
            end
            clear_line();
            return;
        end
        // character that would overfill the line store: dropped, line restarts
        if (ln_len >= LINE_MAX - 1)
        begin
            clear_line();
            return;
        end
        if (!ln_star && !ln_nul)
        begin
            if (b == lxc_pkg::CHAR_STAR)
            begin
                ln_star = 1'b1;
                ln_pay  = ln_len;
            end
            else if (b == lxc_pkg::CHAR_NUL)
                ln_nul = 1'b1;
            else
                ln_xor = ln_xor ^ b;
        end
        else if (ln_star && ln_digits < 2)
        begin
            nib = nib_of(b);
            if (nib < 0)
                ln_badhex = 1'b1;
            else
                ln_chk = {ln_chk[3:0], nib[3:0]};
            ln_digits++;
        end
        ln_len++;
    endfunction

    // sender: presents the next byte at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_fired)
            begin
                if (tx_bytes.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    rx_byte  <= tx_bytes.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_seen != hold_token)
            begin
                hold_seen <= hold_token;
                hold_left <= 400;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin : mon
        verdict_rec_t r;
        if (rst_n)
        begin
            in_fired <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                track_byte(rx_byte);
                n_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction verdict=%0d payload_length=%0d",
                             $time, verdict, payload_length);
                    n_err++;
                end
                else
                begin
                    r = verdict_q.pop_front();
                    if (verdict !== r.v)
                    begin
                        $display("%0t: verdict mismatch: expected %0d, actual %0d",
                                 $time, r.v, verdict);
                        n_err++;
                    end
                    if (payload_length !== r.plen)
                    begin
                        $display("%0t: payload_length mismatch: expected %0d, actual %0d",
                                 $time, r.plen, payload_length);
                        n_err++;
                    end
                end
            end
        end
    end

    task automatic send_b(input logic [7:0] b);
        tx_bytes.push_back(b);
        n_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_b(s[i]);
    endtask

    function automatic logic [7:0] pay_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == lxc_pkg::CHAR_CR || b == lxc_pkg::CHAR_LF || b == lxc_pkg::CHAR_STAR);
        return b;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 10)
            return 8'h30 + n;
        return (($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    task automatic send_line(input line_kind_t kind);
        int         n;
        int         bad_pos;
        logic [7:0] x;
        logic [7:0] b;
        logic [7:0] sum;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 62) : $urandom_range(0, 12);
        x = 8'h00;
        if (kind == LN_NOISE)
        begin
            repeat ($urandom_range(1, 8))
                send_b(8'($urandom_range(0, 255)));
            return;
        end
        if (kind == LN_OVERFLOW)
        begin
            repeat ($urandom_range(LINE_MAX - 1, LINE_MAX + 26))
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == lxc_pkg::CHAR_CR || b == lxc_pkg::CHAR_LF);
                send_b(b);
            end
            send_b(lxc_pkg::CHAR_LF);
            return;
        end
        for (int k = 0; k < n; k++)
        begin
            b = pay_byte();
            x = x ^ b;
            send_b(b);
        end
        if (kind == LN_PLAIN)
        begin
            send_b(pay_byte());
        end
        else
        begin
            if (kind == LN_NULSTAR)
                send_b(lxc_pkg::CHAR_NUL);
            send_b(lxc_pkg::CHAR_STAR);
            sum = x;
            if (kind == LN_BADSUM)
                sum = sum ^ (8'h01 << $urandom_range(0, 7));
            if (kind == LN_SHORT)
            begin
                if ($urandom_range(0, 1) != 0)
                    send_b(hex_char(sum[7:4]));
            end
            else
            begin
                bad_pos = (kind == LN_BADHEX) ? $urandom_range(0, 1) : 2;
                for (int d = 0; d < 2; d++)
                begin
                    if (d == bad_pos)
                    begin
                        do
                            b = 8'($urandom_range(0, 255));
                        while (nib_of(b) >= 0 || b == lxc_pkg::CHAR_CR ||
                               b == lxc_pkg::CHAR_LF);
                        send_b(b);
                    end
                    else
                    begin
                        send_b(hex_char(d == 0 ? sum[7:4] : sum[3:0]));
                    end
                end
            end
        end
        // no trailing bytes on SHORT lines: they would fill the digits
        if (kind != LN_SHORT && $urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3))
                send_b(pay_byte());
        end
        if ($urandom_range(0, 3) == 0)
        begin
            send_b(lxc_pkg::CHAR_CR);
            send_b(lxc_pkg::CHAR_LF);
        end
        else
        begin
            send_b(($urandom_range(0, 1) != 0) ? lxc_pkg::CHAR_CR : lxc_pkg::CHAR_LF);
        end
    endtask

    task automatic send_random(input int count);
        int         r;
        line_kind_t kind;
        int         stop_at;
        stop_at = n_sent + count;
        while (n_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                kind = LN_GOOD;
            else if (r < 58)
                kind = LN_BADSUM;
            else if (r < 63)
                kind = LN_SHORT;
            else if (r < 68)
                kind = LN_BADHEX;
            else if (r < 80)
                kind = LN_PLAIN;
            else if (r < 84)
                kind = LN_NULSTAR;
            else if (r < 88)
                kind = LN_OVERFLOW;
            else
                kind = LN_NOISE;
            send_line(kind);
        end
    endtask

    task automatic drain_bytes();
        while (tx_bytes.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clear_line();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 8;
        rx_idle_pct = 62;

        // directed lines
        send_text("*00");
        send_b(lxc_pkg::CHAR_CR);
        send_b(lxc_pkg::CHAR_LF);
        send_b(lxc_pkg::CHAR_NUL);
        send_text("*7");
        send_b(lxc_pkg::CHAR_LF);
        send_text("J*4aQ");
        send_b(lxc_pkg::CHAR_LF);
        send_text("J*4B");
        send_b(lxc_pkg::CHAR_CR);
        send_text("J*4");
        send_b(lxc_pkg::CHAR_CR);
        send_text("J*");
        send_b(lxc_pkg::CHAR_NUL);
        send_text("A");
        send_b(lxc_pkg::CHAR_CR);
        send_b(8'hFF);
        send_b(lxc_pkg::CHAR_CR);
        send_text("e*G5");
        send_b(lxc_pkg::CHAR_LF);

        send_random(650);
        drain_bytes();

        tx_idle_pct = 62;
        rx_idle_pct = 8;
        send_random(650);
        drain_bytes();

        // no idling; receiver holds off while lines keep coming
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(420);
        hold_token = hold_token + 1;
        drain_bytes();

        while (n_taken != n_sent || verdict_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (verdict_q.size() != 0)
        begin
            $display("%0t: %0d expected transactions never arrived", $time, verdict_q.size());
            n_err++;
        end
        if (n_err == 0)
            $display("line_xor_checksum_checker_core regression: pass");
        else
            $display("line_xor_checksum_checker_core regression: fail");
        $finish;
    end

endmodule
